[design/asdc_pkg.sv]
// shared widths, constants and state types of the step detector
`timescale 1ns / 1ps
`default_nettype none

package asdc_pkg;

    localparam int AXIS_W     = 13;
    localparam int MAG_W      = 13;
    localparam int SQ_W       = 26;
    localparam int REM_W      = 15;
    localparam int SUM_W      = 21;
    localparam int THR_W      = 13;
    localparam int CALIB_W    = 8;
    localparam int PWIN_W     = 8;
    localparam int STEP_W     = 16;
    localparam int SPM_W      = 16;
    localparam int TIME_W     = 32;
    localparam int DIV_W      = 24;
    localparam int CNT_W      = 5;
    localparam int ROOT_STEPS = 13;
    localparam int AXES       = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CNT_W-1:0] SQ_LAST   = CNT_W'(AXES - 1);
    localparam logic [CNT_W-1:0] ROOT_LAST = CNT_W'(ROOT_STEPS - 1);
    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(DIV_W - 1);

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CALIB  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PWIN   = 2'd2;

    localparam logic [THR_W-1:0]   THR_RST   = 13'd1200;
    localparam logic [CALIB_W-1:0] CALIB_RST = 8'd20;
    localparam logic [PWIN_W-1:0]  PWIN_RST  = 8'd5;
    localparam logic [CALIB_W-1:0] CALIB_MIN = 8'd2;
    localparam logic [PWIN_W-1:0]  PWIN_MIN  = 8'd1;
    localparam logic [SPM_W-1:0]   SPM_NUM   = 16'd60000;
    localparam logic [SPM_W-1:0]   SAT16     = 16'hFFFF;
    localparam logic [MAG_W-1:0]   MAG_MAX   = 13'd7094;

    // input beat operations
    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_WINDOW = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQ,
        S_ROOT,
        S_CALIB,
        S_DIV,
        S_DIV_END,
        S_DETECT,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        DIV_BASE,
        DIV_RATE,
        DIV_PACE
    } t_div_sel;

endpackage

`default_nettype wire

[design/asdc_in_if.sv]
// input channel: samples and pace window start commands
`timescale 1ns / 1ps
`default_nettype none

interface asdc_in_if;
    logic                                valid;
    logic                                ready;
    logic                                op;
    logic signed [asdc_pkg::AXIS_W-1:0]  accel_x;
    logic signed [asdc_pkg::AXIS_W-1:0]  accel_y;
    logic signed [asdc_pkg::AXIS_W-1:0]  accel_z;
    logic        [asdc_pkg::TIME_W-1:0]  time_ms;

    modport source (output valid, op, accel_x, accel_y, accel_z, time_ms, input ready);
    modport sink   (input valid, op, accel_x, accel_y, accel_z, time_ms, output ready);
endinterface

`default_nettype wire

[design/asdc_out_if.sv]
// result channel: step count, cadence and averaged pace
`timescale 1ns / 1ps
`default_nettype none

interface asdc_out_if;
    logic                         valid;
    logic                         ready;
    logic                         calibrating;
    logic [asdc_pkg::STEP_W-1:0]  step_count;
    logic                         rate_valid;
    logic [asdc_pkg::SPM_W-1:0]   rate_spm;
    logic                         pace_done;
    logic [asdc_pkg::SPM_W-1:0]   pace_spm;

    modport source (output valid, calibrating, step_count, rate_valid, rate_spm,
                    pace_done, pace_spm, input ready);
    modport sink   (input valid, calibrating, step_count, rate_valid, rate_spm,
                    pace_done, pace_spm, output ready);
endinterface

`default_nettype wire

[design/accel_step_detector_cadence.sv]
// step detector top level: magnitude, baseline, step rate and averaged pace
//
//  channel   | dir | beat
//  ----------+-----+-------------------------------------------------------
//  i_smp     | in  | op, accel_x/y/z, time_ms; valid/ready
//  o_res     | out | calibrating, step_count, rate, pace; valid/ready
//  i_cfg_*   | in  | write enable, register index, data; no back-pressure
//
//  a start command goes straight to the result register; a sample squares the
//  axes one by one on one multiplier, takes the two-bit-per-cycle square root
//  and then uses the shared one-bit-per-cycle divider for each division: baseline,
//  step rate, pace; no sample needs more than two
//  one item is in work at a time; the result register frees the input side
//  reset is synchronous and needs no clearing pass
//  a stalled result holds the block in its output state until taken
`timescale 1ns / 1ps
`default_nettype none

module accel_step_detector_cadence (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    asdc_in_if.sink                                 i_smp,
    asdc_out_if.source                              o_res,
    input  wire logic                               i_cfg_we,
    input  wire logic [asdc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [asdc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import asdc_pkg::*;

    t_state                    r_state, n_state;
    logic [CNT_W-1:0]          r_cnt, n_cnt;

    // item being worked on
    logic signed [AXIS_W-1:0]  r_ax, n_ax, r_ay, n_ay, r_az, n_az;
    logic [TIME_W-1:0]         r_time, n_time;

    // square root shift registers
    logic [SQ_W-1:0]           r_rad, n_rad;
    logic [REM_W-1:0]          r_rem, n_rem;
    logic [MAG_W-1:0]          r_root, n_root;

    // shared divider
    logic [DIV_W-1:0]          r_dq, n_dq;
    logic [TIME_W-1:0]         r_dr, n_dr, r_dd, n_dd;
    t_div_sel                  r_div_sel, n_div_sel;
    logic                      r_do_pace, n_do_pace;
    logic                      r_pace_done, n_pace_done;

    // detector state
    logic [CALIB_W-1:0]        r_smp_cnt, n_smp_cnt;
    logic [SUM_W-1:0]          r_mag_sum, n_mag_sum;
    logic [MAG_W-1:0]          r_baseline, n_baseline;
    logic                      r_calib_done, n_calib_done;
    logic [STEP_W-1:0]         r_steps, n_steps;
    logic [TIME_W-1:0]         r_last_step, n_last_step;
    logic [SPM_W-1:0]          r_last_rate, n_last_rate;
    logic                      r_win_active, n_win_active;
    logic [PWIN_W-1:0]         r_win_steps, n_win_steps;
    logic [TIME_W-1:0]         r_win_start, n_win_start;
    logic [SPM_W-1:0]          r_last_pace, n_last_pace;

    // configuration
    logic [THR_W-1:0]          r_thresh;
    logic [CALIB_W-1:0]        r_calib;
    logic [PWIN_W-1:0]         r_pwin;

    // result register
    logic                      r_out_valid, n_out_valid;
    logic                      r_o_calib, n_o_calib;
    logic [STEP_W-1:0]         r_o_steps, n_o_steps;
    logic                      r_o_rvalid, n_o_rvalid;
    logic [SPM_W-1:0]          r_o_rate, n_o_rate;
    logic                      r_o_pdone, n_o_pdone;
    logic [SPM_W-1:0]          r_o_pace, n_o_pace;

    // datapath pieces
    logic signed [AXIS_W-1:0]  w_axis;
    logic [AXIS_W-1:0]         w_abs;
    logic [SQ_W-1:0]           w_sq;
    logic [REM_W+1:0]          w_rem_sh, w_trial, w_rem_sub;
    logic                      w_root_ge;
    logic [TIME_W:0]           w_dr_sh, w_dr_sub;
    logic                      w_div_ge;
    logic [CALIB_W-1:0]        w_cnt_next, w_n;
    logic [SUM_W-1:0]          w_add;
    logic [MAG_W-1:0]          w_delta;
    logic                      w_step;
    logic [PWIN_W-1:0]         w_k, w_win_next;
    logic                      w_close;
    logic [DIV_W-1:0]          w_pace_num;
    logic [SPM_W-1:0]          w_sat;

    always_comb begin
        case (r_cnt[1:0])
            2'd0:    w_axis = r_ax;
            2'd1:    w_axis = r_ay;
            default: w_axis = r_az;
        endcase
    end

    assign w_abs = w_axis[AXIS_W-1] ? (~w_axis + AXIS_W'(1)) : w_axis;
    assign w_sq  = {{(SQ_W-AXIS_W){1'b0}}, w_abs} * {{(SQ_W-AXIS_W){1'b0}}, w_abs};

    // one root digit per cycle from the top two radicand bits
    assign w_rem_sh  = {r_rem, r_rad[SQ_W-1 -: 2]};
    assign w_trial   = {2'b00, r_root, 2'b01};
    assign w_root_ge = (w_rem_sh >= w_trial);
    assign w_rem_sub = w_rem_sh - w_trial;

    // restoring division; a zero divisor yields all ones, which saturates
    assign w_dr_sh  = {r_dr, r_dq[DIV_W-1]};
    assign w_div_ge = (w_dr_sh >= {1'b0, r_dd});
    assign w_dr_sub = w_dr_sh - {1'b0, r_dd};
    assign w_sat    = (|r_dq[DIV_W-1:SPM_W]) ? SAT16 : r_dq[SPM_W-1:0];

    assign w_cnt_next = r_smp_cnt + CALIB_W'(1);
    assign w_n        = (r_calib < CALIB_MIN) ? CALIB_MIN : r_calib;
    // first sample counts twice
    assign w_add      = (w_cnt_next == CALIB_W'(1)) ? {{(SUM_W-MAG_W-1){1'b0}}, r_root, 1'b0}
                                                    : {{(SUM_W-MAG_W){1'b0}}, r_root};

    assign w_delta = (r_root > r_baseline) ? (r_root - r_baseline) : (r_baseline - r_root);
    assign w_step  = (w_delta > r_thresh);

    assign w_k        = (r_pwin == '0) ? PWIN_MIN : r_pwin;
    assign w_win_next = r_win_steps + PWIN_W'(1);
    assign w_close    = r_win_active && (w_win_next >= w_k);
    assign w_pace_num = DIV_W'(w_k) * DIV_W'(SPM_NUM);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        logic              ld;
        logic [DIV_W-1:0]  ld_num;
        logic [TIME_W-1:0] ld_den;
        t_div_sel          ld_sel;
        logic              out_load;

        ld           = 1'b0;
        ld_num       = '0;
        ld_den       = '0;
        ld_sel       = DIV_BASE;
        out_load     = 1'b0;

        n_state      = r_state;
        n_cnt        = r_cnt;
        n_ax         = r_ax;
        n_ay         = r_ay;
        n_az         = r_az;
        n_time       = r_time;
        n_rad        = r_rad;
        n_rem        = r_rem;
        n_root       = r_root;
        n_dq         = r_dq;
        n_dr         = r_dr;
        n_dd         = r_dd;
        n_div_sel    = r_div_sel;
        n_do_pace    = r_do_pace;
        n_pace_done  = r_pace_done;
        n_smp_cnt    = r_smp_cnt;
        n_mag_sum    = r_mag_sum;
        n_baseline   = r_baseline;
        n_calib_done = r_calib_done;
        n_steps      = r_steps;
        n_last_step  = r_last_step;
        n_last_rate  = r_last_rate;
        n_win_active = r_win_active;
        n_win_steps  = r_win_steps;
        n_win_start  = r_win_start;
        n_last_pace  = r_last_pace;

        case (r_state)
            S_IDLE: begin
                if (i_smp.valid) begin
                    n_ax        = i_smp.accel_x;
                    n_ay        = i_smp.accel_y;
                    n_az        = i_smp.accel_z;
                    n_time      = i_smp.time_ms;
                    n_pace_done = 1'b0;
                    n_cnt       = '0;
                    n_rad       = '0;
                    if (i_smp.op == OP_WINDOW) begin
                        n_win_active = 1'b1;
                        n_win_steps  = '0;
                        n_win_start  = i_smp.time_ms;
                        n_state      = S_OUT;
                    end else begin
                        n_state = S_SQ;
                    end
                end
            end
            S_SQ: begin
                n_rad = r_rad + w_sq;
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == SQ_LAST) begin
                    n_cnt   = '0;
                    n_rem   = '0;
                    n_root  = '0;
                    n_state = S_ROOT;
                end
            end
            S_ROOT: begin
                n_rad = {r_rad[SQ_W-3:0], 2'b00};
                n_cnt = r_cnt + CNT_W'(1);
                if (w_root_ge) begin
                    n_rem  = REM_W'(w_rem_sub);
                    n_root = {r_root[MAG_W-2:0], 1'b1};
                end else begin
                    n_rem  = REM_W'(w_rem_sh);
                    n_root = {r_root[MAG_W-2:0], 1'b0};
                end
                if (r_cnt == ROOT_LAST) begin
                    n_state = S_CALIB;
                end
            end
            S_CALIB: begin
                if (r_calib_done) begin
                    n_state = S_DETECT;
                end else begin
                    n_smp_cnt = w_cnt_next;
                    if (w_cnt_next < w_n) begin
                        n_mag_sum = r_mag_sum + w_add;
                        n_state   = S_OUT;
                    end else begin
                        ld     = 1'b1;
                        ld_num = DIV_W'(r_mag_sum);
                        ld_den = TIME_W'(w_n);
                        ld_sel = DIV_BASE;
                    end
                end
            end
            S_DIV: begin
                n_cnt = r_cnt + CNT_W'(1);
                if (w_div_ge) begin
                    n_dr = TIME_W'(w_dr_sub);
                    n_dq = {r_dq[DIV_W-2:0], 1'b1};
                end else begin
                    n_dr = TIME_W'(w_dr_sh);
                    n_dq = {r_dq[DIV_W-2:0], 1'b0};
                end
                if (r_cnt == DIV_LAST) begin
                    n_state = S_DIV_END;
                end
            end
            S_DIV_END: begin
                case (r_div_sel)
                    DIV_BASE: begin
                        n_baseline   = r_dq[MAG_W-1:0];
                        n_calib_done = 1'b1;
                        n_state      = S_DETECT;
                    end
                    DIV_RATE: begin
                        n_last_rate = w_sat;
                        if (r_do_pace) begin
                            ld     = 1'b1;
                            ld_num = w_pace_num;
                            ld_den = r_time - r_win_start;
                            ld_sel = DIV_PACE;
                        end else begin
                            n_state = S_OUT;
                        end
                    end
                    DIV_PACE: begin
                        n_last_pace = w_sat;
                        n_state     = S_OUT;
                    end
                    default: begin
                        n_state = S_OUT;
                    end
                endcase
            end
            S_DETECT: begin
                n_state = S_OUT;
                if (w_step) begin
                    if (r_steps != SAT16) begin
                        n_steps = r_steps + STEP_W'(1);
                    end
                    n_last_step = r_time;
                    n_do_pace   = w_close;
                    if (w_close) begin
                        n_win_active = 1'b0;
                        n_win_steps  = '0;
                        n_pace_done  = 1'b1;
                    end else if (r_win_active) begin
                        n_win_steps = w_win_next;
                    end
                    // interval uses the previous step time, latched by the divider
                    if (r_steps != '0) begin
                        ld     = 1'b1;
                        ld_num = DIV_W'(SPM_NUM);
                        ld_den = r_time - r_last_step;
                        ld_sel = DIV_RATE;
                    end else if (w_close) begin
                        ld     = 1'b1;
                        ld_num = w_pace_num;
                        ld_den = r_time - r_win_start;
                        ld_sel = DIV_PACE;
                    end
                end
            end
            S_OUT: begin
                if (!r_out_valid || o_res.ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (ld) begin
            n_dq      = ld_num;
            n_dr      = '0;
            n_dd      = ld_den;
            n_div_sel = ld_sel;
            n_cnt     = '0;
            n_state   = S_DIV;
        end

        n_o_calib  = r_o_calib;
        n_o_steps  = r_o_steps;
        n_o_rvalid = r_o_rvalid;
        n_o_rate   = r_o_rate;
        n_o_pdone  = r_o_pdone;
        n_o_pace   = r_o_pace;
        if (out_load) begin
            n_o_calib  = !r_calib_done;
            n_o_steps  = r_steps;
            n_o_rvalid = (r_steps >= STEP_W'(2));
            n_o_rate   = (r_steps >= STEP_W'(2)) ? r_last_rate : '0;
            n_o_pdone  = r_pace_done;
            n_o_pace   = r_last_pace;
        end
        n_out_valid = out_load ? 1'b1 : (o_res.ready ? 1'b0 : r_out_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt        <= '0;
            r_do_pace    <= 1'b0;
            r_pace_done  <= 1'b0;
            r_div_sel    <= DIV_BASE;
            r_smp_cnt    <= '0;
            r_mag_sum    <= '0;
            r_baseline   <= '0;
            r_calib_done <= 1'b0;
            r_steps      <= '0;
            r_last_step  <= '0;
            r_last_rate  <= '0;
            r_win_active <= 1'b0;
            r_win_steps  <= '0;
            r_win_start  <= '0;
            r_last_pace  <= '0;
            r_thresh     <= THR_RST;
            r_calib      <= CALIB_RST;
            r_pwin       <= PWIN_RST;
            r_out_valid  <= 1'b0;
        end else begin
            r_cnt        <= n_cnt;
            r_do_pace    <= n_do_pace;
            r_pace_done  <= n_pace_done;
            r_div_sel    <= n_div_sel;
            r_smp_cnt    <= n_smp_cnt;
            r_mag_sum    <= n_mag_sum;
            r_baseline   <= n_baseline;
            r_calib_done <= n_calib_done;
            r_steps      <= n_steps;
            r_last_step  <= n_last_step;
            r_last_rate  <= n_last_rate;
            r_win_active <= n_win_active;
            r_win_steps  <= n_win_steps;
            r_win_start  <= n_win_start;
            r_last_pace  <= n_last_pace;
            r_out_valid  <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_THRESH: r_thresh <= i_cfg_data[THR_W-1:0];
                    CFG_CALIB:  r_calib  <= i_cfg_data[CALIB_W-1:0];
                    CFG_PWIN:   r_pwin   <= i_cfg_data[PWIN_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_ax       <= n_ax;
        r_ay       <= n_ay;
        r_az       <= n_az;
        r_time     <= n_time;
        r_rad      <= n_rad;
        r_rem      <= n_rem;
        r_root     <= n_root;
        r_dq       <= n_dq;
        r_dr       <= n_dr;
        r_dd       <= n_dd;
        r_o_calib  <= n_o_calib;
        r_o_steps  <= n_o_steps;
        r_o_rvalid <= n_o_rvalid;
        r_o_rate   <= n_o_rate;
        r_o_pdone  <= n_o_pdone;
        r_o_pace   <= n_o_pace;
    end

    assign i_smp.ready       = (r_state == S_IDLE);
    assign o_res.valid       = r_out_valid;
    assign o_res.calibrating = r_o_calib;
    assign o_res.step_count  = r_o_steps;
    assign o_res.rate_valid  = r_o_rvalid;
    assign o_res.rate_spm    = r_o_rate;
    assign o_res.pace_done   = r_o_pdone;
    assign o_res.pace_spm    = r_o_pace;

    // baseline, once formed, stays formed
    a_calib_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_calib_done |=> r_calib_done)
        else $error("calibration done flag dropped");

    // step count never goes backwards
    a_steps_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_steps != '0) |=> (r_steps >= $past(r_steps)))
        else $error("step count decreased");

    // a pace quotient only lands after its window has closed
    a_pace_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV_END && r_div_sel == DIV_PACE) |-> (!r_win_active && r_pace_done))
        else $error("pace finished with window still open");

    // root of three 13-bit squares is bounded
    a_root_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CALIB) |-> (r_root <= MAG_MAX))
        else $error("magnitude out of range");

    // a waiting result is never overwritten
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_out_valid && !o_res.ready) |=> (r_state == S_OUT))
        else $error("result overwritten while stalled");

endmodule

`default_nettype wire
